>>> src/qfwp_pkg.sv
// qfwp_pkg: types and constants shared by the quad fragment warp packer.
// Holds the field widths, the front-to-back request type and the front state enum.
// No dependencies.
package qfwp_pkg;

	localparam int COV_W      = 4;
	localparam int STAMP_W    = 26;
	localparam int POS_HI_W   = STAMP_W - COV_W;
	localparam int PRIM_W     = 32;
	localparam int LANE_W     = 5;
	localparam int PIX_W      = 12;
	localparam int SLOT_W     = 3;
	localparam int SUB_W      = 2;
	localparam int FIFO_DEPTH = 4;

	typedef struct packed {
		logic                marker;
		logic                last;
		logic [SLOT_W-1:0]   slot;
		logic [STAMP_W-1:0]  bits;
		logic [PRIM_W-1:0]   prim;
	} qfwp_req_t;

	typedef enum logic [2:0] {
		FR_IDLE,
		FR_CHECK,
		FR_FLUSH,
		FR_STORE,
		FR_LOAD
	} front_state_t;

endpackage

>>> src/qfwp_front.sv
// qfwp_front: accepts stamps and drain requests, holds the open pack
// (quads, positions and count) and on a flush issues its quads to the back, then a marker for a drain.
// Depends on qfwp_pkg.
module qfwp_front #(
	parameter int PACK_QUADS = 8
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    push,
	output logic                    full,
	input  logic                    mode,
	input  logic [qfwp_pkg::STAMP_W-1:0] stamp_bits,
	input  logic [qfwp_pkg::PRIM_W-1:0]  prim_id,
	output logic                    req_push,
	input  logic                    req_full,
	output qfwp_pkg::qfwp_req_t     req
);
	import qfwp_pkg::*;

	localparam int CW = $clog2(PACK_QUADS + 1);
	localparam int IW = (PACK_QUADS > 1) ? $clog2(PACK_QUADS) : 1;
	localparam int QW = STAMP_W + PRIM_W;

	front_state_t state_q, state_d;

	logic                item_mode_q;
	logic [STAMP_W-1:0]  item_bits_q;
	logic [PRIM_W-1:0]   item_prim_q;
	logic [POS_HI_W-1:0] tag_q [PACK_QUADS];
	logic [QW-1:0]       quad_mem_q [PACK_QUADS];
	logic [QW-1:0]       rd_q;
	logic [CW-1:0]       count_q, count_d;
	logic [IW-1:0]       idx_q, idx_d;
	logic                fill_q, fill_d;

	logic          collide, is_blank, last_quad, wr_store;
	logic [IW-1:0] wr_slot;

	assign wr_slot = IW'(count_q);

	always_comb begin
		collide = 1'b0;
		for (int j = 0; j < PACK_QUADS; j++) begin
			if ((CW'(j) < count_q) && (tag_q[j] == item_bits_q[STAMP_W-1:COV_W]))
				collide = 1'b1;
		end
		is_blank  = (item_bits_q[COV_W-1:0] == '0);
		last_quad = ((CW'(idx_q) + CW'(1)) == count_q);
	end

	always_comb begin
		state_d  = state_q;
		count_d  = count_q;
		idx_d    = idx_q;
		fill_d   = fill_q;
		wr_store = 1'b0;
		req_push = 1'b0;
		req      = '0;
		full     = (state_q != FR_IDLE);
		case (state_q)
			FR_IDLE: begin
				if (push)
					state_d = FR_CHECK;
			end
			FR_CHECK: begin
				fill_d = 1'b0;
				if (!item_mode_q && is_blank)
					state_d = FR_IDLE;
				else if ((item_mode_q || collide) && (count_q != '0)) begin
					idx_d   = '0;
					state_d = FR_FLUSH;
				end else
					state_d = FR_STORE;
			end
			FR_FLUSH: begin
				req_push = 1'b1;
				req.last = last_quad;
				req.slot = SLOT_W'(idx_q);
				req.bits = rd_q[PRIM_W +: STAMP_W];
				req.prim = rd_q[PRIM_W-1:0];
				if (!req_full) begin
					if (last_quad) begin
						count_d = '0;
						idx_d   = '0;
						state_d = fill_q ? FR_IDLE : FR_STORE;
					end else
						idx_d = idx_q + IW'(1);
				end
			end
			FR_STORE: begin
				if (item_mode_q) begin
					req_push   = 1'b1;
					req.marker = 1'b1;
					if (!req_full)
						state_d = FR_IDLE;
				end else begin
					wr_store = 1'b1;
					count_d  = count_q + CW'(1);
					if (count_d == CW'(PACK_QUADS)) begin
						fill_d  = 1'b1;
						state_d = FR_LOAD;
					end else
						state_d = FR_IDLE;
				end
			end
			// slot 0 read again after the store that completed the pack
			FR_LOAD: state_d = FR_FLUSH;
			default: state_d = FR_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= FR_IDLE;
			count_q <= '0;
			idx_q   <= '0;
			fill_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			count_q <= count_d;
			idx_q   <= idx_d;
			fill_q  <= fill_d;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == FR_IDLE && push) begin
			item_mode_q <= mode;
			item_bits_q <= stamp_bits;
			item_prim_q <= prim_id;
		end
		if (wr_store) begin
			tag_q[wr_slot]      <= item_bits_q[STAMP_W-1:COV_W];
			quad_mem_q[wr_slot] <= {item_bits_q, item_prim_q};
		end
		rd_q <= quad_mem_q[idx_d];
	end

endmodule

>>> src/qfwp_req_fifo.sv
// qfwp_req_fifo: short request queue between the front and the back.
// Register array with read and write pointers and an occupancy count.
// Depends on qfwp_pkg.
module qfwp_req_fifo (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                wr_en,
	input  qfwp_pkg::qfwp_req_t wr_data,
	output logic                wr_full,
	input  logic                rd_en,
	output qfwp_pkg::qfwp_req_t rd_data,
	output logic                rd_empty
);
	import qfwp_pkg::*;

	localparam int PW = $clog2(FIFO_DEPTH);
	localparam int NW = $clog2(FIFO_DEPTH + 1);

	qfwp_req_t      mem_q [FIFO_DEPTH];
	logic [PW-1:0]  wptr_q, rptr_q;
	logic [NW-1:0]  cnt_q;
	logic           do_wr, do_rd;

	assign wr_full  = (cnt_q == NW'(FIFO_DEPTH));
	assign rd_empty = (cnt_q == '0);
	assign do_wr    = wr_en && !wr_full;
	assign do_rd    = rd_en && !rd_empty;
	assign rd_data  = mem_q[rptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q <= '0;
			rptr_q <= '0;
			cnt_q  <= '0;
		end else begin
			if (do_wr)
				wptr_q <= wptr_q + PW'(1);
			if (do_rd)
				rptr_q <= rptr_q + PW'(1);
			if (do_wr && !do_rd)
				cnt_q <= cnt_q + NW'(1);
			else if (do_rd && !do_wr)
				cnt_q <= cnt_q - NW'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (do_wr)
			mem_q[wptr_q] <= wr_data;
	end

endmodule

>>> src/qfwp_back.sv
// qfwp_back: expands each quad request into four lanes and each marker request
// into one marker result, through an output register: one a cycle while pop frees it.
// Depends on qfwp_pkg.
module qfwp_back #(
	parameter int POS_BITS = 11
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        req_empty,
	input  qfwp_pkg::qfwp_req_t         req,
	output logic                        req_pop,
	output logic                        empty,
	input  logic                        pop,
	output logic [qfwp_pkg::LANE_W-1:0] lane,
	output logic [qfwp_pkg::PIX_W-1:0]  pix_x,
	output logic [qfwp_pkg::PIX_W-1:0]  pix_y,
	output logic                        covered,
	output logic [qfwp_pkg::PRIM_W-1:0] frag_prim,
	output logic                        wave_last,
	output logic                        drain_marker
);
	import qfwp_pkg::*;

	qfwp_req_t          cur_q;
	logic               cur_v_q, out_v_q;
	logic [SUB_W-1:0]   sub_q;
	logic               ld, fin;
	logic [STAMP_W-1:0] shx, shy;
	logic [COV_W-1:0]   cov;

	assign ld      = cur_v_q && (!out_v_q || pop);
	assign fin     = cur_q.marker || (sub_q == SUB_W'(3));
	assign req_pop = !req_empty && (!cur_v_q || (ld && fin));
	assign empty   = !out_v_q;
	assign shx     = cur_q.bits >> COV_W;
	assign shy     = cur_q.bits >> (COV_W + POS_BITS);
	assign cov     = cur_q.bits[COV_W-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_v_q <= 1'b0;
			out_v_q <= 1'b0;
			sub_q   <= '0;
		end else begin
			if (req_pop) begin
				cur_v_q <= 1'b1;
				sub_q   <= '0;
			end else if (ld) begin
				if (fin)
					cur_v_q <= 1'b0;
				else
					sub_q <= sub_q + SUB_W'(1);
			end
			if (ld)
				out_v_q <= 1'b1;
			else if (pop)
				out_v_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (req_pop)
			cur_q <= req;
		if (ld) begin
			if (cur_q.marker) begin
				lane      <= '0;
				pix_x     <= '0;
				pix_y     <= '0;
				covered   <= 1'b0;
				frag_prim <= '0;
				wave_last <= 1'b0;
			end else begin
				lane      <= LANE_W'({cur_q.slot, sub_q});
				pix_x     <= PIX_W'({shx[POS_BITS-1:0], sub_q[0]});
				pix_y     <= PIX_W'({shy[POS_BITS-1:0], sub_q[1]});
				covered   <= cov[sub_q];
				frag_prim <= cur_q.prim;
				wave_last <= cur_q.last && (sub_q == SUB_W'(3));
			end
			drain_marker <= cur_q.marker;
		end
	end

endmodule

>>> src/quad_fragment_warp_packer_unit.sv
// quad_fragment_warp_packer_unit: packs 2x2 quad stamps into fragment warps.
// Front (pack tracking), request queue and back (lane expansion) below.
// Depends on qfwp_pkg, qfwp_front, qfwp_req_fifo, qfwp_back.
//
// Input side is a queue: a request is taken when push is high and full is low.
// mode 0 is a quad stamp, mode 1 drains the open pack and then yields a marker.
// The front takes each request through capture, check, and store or marker,
// flushing its quads into the queue first on a drain or position collision
// and after a stamp that completes the pack; full stays high until it is done.
// Output side is a queue: the oldest result sits on the ports while empty is
// low and leaves when pop is high. The back emits one result a cycle while
// pop keeps its output register free: four lanes per flushed quad, one for
// the marker, so a full warp of PACK_QUADS quads gives 4*PACK_QUADS results.
// A result passes from the front through the request queue and the back's
// current-request register into the output register. The back takes its next
// request from the queue as it issues the last result of the current one.
// If pop stays low the output register holds, the back stops, the four-entry
// queue fills and the front then holds full high at its next flush or marker;
// nothing is lost. Reset empties the pack, the queue and the output register.
module quad_fragment_warp_packer_unit #(
	parameter int PACK_QUADS = 8,
	parameter int POS_BITS   = 11
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        push,
	output logic                        full,
	input  logic                        mode,
	input  logic [qfwp_pkg::STAMP_W-1:0] stamp_bits,
	input  logic [qfwp_pkg::PRIM_W-1:0] prim_id,
	output logic                        empty,
	input  logic                        pop,
	output logic [qfwp_pkg::LANE_W-1:0] lane,
	output logic [qfwp_pkg::PIX_W-1:0]  pix_x,
	output logic [qfwp_pkg::PIX_W-1:0]  pix_y,
	output logic                        covered,
	output logic [qfwp_pkg::PRIM_W-1:0] frag_prim,
	output logic                        wave_last,
	output logic                        drain_marker
);
	import qfwp_pkg::*;

	qfwp_req_t wr_req, rd_req;
	logic      wr_en, wr_full, rd_en, rd_empty;

	qfwp_front #(
		.PACK_QUADS(PACK_QUADS)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.full      (full),
		.mode      (mode),
		.stamp_bits(stamp_bits),
		.prim_id   (prim_id),
		.req_push  (wr_en),
		.req_full  (wr_full),
		.req       (wr_req)
	);

	qfwp_req_fifo u_fifo (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (wr_en),
		.wr_data (wr_req),
		.wr_full (wr_full),
		.rd_en   (rd_en),
		.rd_data (rd_req),
		.rd_empty(rd_empty)
	);

	qfwp_back #(
		.POS_BITS(POS_BITS)
	) u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.req_empty   (rd_empty),
		.req         (rd_req),
		.req_pop     (rd_en),
		.empty       (empty),
		.pop         (pop),
		.lane        (lane),
		.pix_x       (pix_x),
		.pix_y       (pix_y),
		.covered     (covered),
		.frag_prim   (frag_prim),
		.wave_last   (wave_last),
		.drain_marker(drain_marker)
	);

endmodule
